[sv/tsp_pkg.sv]
package tsp_pkg;

	// Width of each field accumulator; fields wrap modulo 2^FIELD_BITS
	localparam int FIELD_BITS = 32;
	// Width of each result field on the output channel
	localparam int OUT_BITS   = 32;
	localparam int NUM_FIELDS = 7;
	localparam int EXT_BITS   = (FIELD_BITS > OUT_BITS) ? FIELD_BITS : OUT_BITS;

	localparam logic [7:0] CH_T     = 8'h54;
	localparam logic [7:0] CH_Z     = 8'h5A;
	localparam logic [7:0] CH_MINUS = 8'h2D;
	localparam logic [7:0] CH_PLUS  = 8'h2B;
	localparam logic [7:0] CH_COLON = 8'h3A;
	localparam logic [7:0] CH_DOT   = 8'h2E;
	localparam logic [7:0] CH_COMMA = 8'h2C;
	localparam logic [7:0] CH_ZERO  = 8'h30;
	localparam logic [7:0] CH_NINE  = 8'h39;
	localparam logic [7:0] CH_SPACE = 8'h20;
	localparam logic [7:0] CH_TAB   = 8'h09;
	localparam logic [7:0] CH_CR    = 8'h0D;

	typedef logic [FIELD_BITS-1:0] field_t;
	typedef logic [OUT_BITS-1:0]   out_field_t;

	// Field index, also the parse phase
	typedef enum logic [2:0] {
		FLD_YEAR   = 3'd0,
		FLD_MONTH  = 3'd1,
		FLD_DAY    = 3'd2,
		FLD_HOUR   = 3'd3,
		FLD_MINUTE = 3'd4,
		FLD_SECOND = 3'd5,
		FLD_FRAC   = 3'd6
	} field_idx_t;

	typedef struct packed {
		logic       status;
		out_field_t year;
		out_field_t month;
		out_field_t day;
		out_field_t hour;
		out_field_t minute;
		out_field_t second;
		out_field_t fraction;
	} result_t;

	// Sign-extend from FIELD_BITS, then cut to OUT_BITS
	function automatic out_field_t to_out(input field_t v);
		logic signed [EXT_BITS-1:0] x;
		x = EXT_BITS'(signed'(v));
		return x[OUT_BITS-1:0];
	endfunction

endpackage

[sv/tsp_char_if.sv]
interface tsp_char_if;
	logic       valid;
	logic       ready;
	logic [7:0] ch;
	logic       last;

	modport source(output valid, ch, last, input ready);
	modport sink(input valid, ch, last, output ready);
endinterface

[sv/tsp_result_if.sv]
interface tsp_result_if import tsp_pkg::*; ();
	logic       valid;
	logic       ready;
	logic       status;
	out_field_t year;
	out_field_t month;
	out_field_t day;
	out_field_t hour;
	out_field_t minute;
	out_field_t second;
	out_field_t fraction;

	modport source(output valid, status, year, month, day, hour, minute, second, fraction,
		input ready);
	modport sink(input valid, status, year, month, day, hour, minute, second, fraction,
		output ready);
endinterface

[sv/tsp_field_parser.sv]
module tsp_field_parser import tsp_pkg::*; (
	input  logic       clk,
	input  logic       arst_n,
	input  logic       take,
	input  logic [7:0] ch,
	input  logic       last,
	output result_t    result
);

	typedef enum logic [1:0] {
		V_OPEN = 2'd0,
		V_OK   = 2'd1,
		V_BAD  = 2'd2
	} verdict_t;

	field_idx_t phase_q, phase_d;
	field_t     acc_q, acc_d;
	logic       neg_q, neg_d;
	logic       sign_q, sign_d;
	logic       dig_q, dig_d;
	verdict_t   verdict_q, verdict_d;
	field_t     store_q [NUM_FIELDS];
	field_t     store_d [NUM_FIELDS];

	logic       num_ch, is_blank;
	field_t     acc_step;
	field_t     digit_val;

	assign num_ch    = (ch >= CH_ZERO) && (ch <= CH_NINE);
	assign is_blank  = (ch == CH_SPACE) || ((ch >= CH_TAB) && (ch <= CH_CR));
	assign digit_val = FIELD_BITS'(ch - CH_ZERO);
	// acc * 10 + digit
	assign acc_step  = (acc_q << 3) + (acc_q << 1) + digit_val;

	always_comb begin
		phase_d   = phase_q;
		acc_d     = acc_q;
		neg_d     = neg_q;
		sign_d    = sign_q;
		dig_d     = dig_q;
		verdict_d = verdict_q;
		store_d   = store_q;

		if (verdict_q == V_OPEN) begin
			if (num_ch) begin
				acc_d   = acc_step;
				dig_d   = 1'b1;
				store_d[phase_q] = neg_q ? (field_t'(0) - acc_step) : acc_step;
			end else if (!dig_q) begin
				if (phase_q == FLD_YEAR || sign_q) begin
					verdict_d = V_BAD;
				end else if (is_blank) begin
					// skip leading whitespace
				end else if (ch == CH_PLUS || ch == CH_MINUS) begin
					sign_d = 1'b1;
					neg_d  = (ch == CH_MINUS);
				end else begin
					verdict_d = V_BAD;
				end
			end else begin
				// separator after a field's digits opens the next field
				acc_d  = '0;
				neg_d  = 1'b0;
				sign_d = 1'b0;
				dig_d  = 1'b0;
				if (ch == CH_Z) begin
					verdict_d = V_OK;
				end else if (ch == CH_MINUS && phase_q <= FLD_MONTH) begin
					phase_d = field_idx_t'(phase_q + 3'd1);
				end else if (ch == CH_T && phase_q <= FLD_DAY) begin
					phase_d = FLD_HOUR;
				end else if (ch == CH_COLON && (phase_q == FLD_HOUR || phase_q == FLD_MINUTE)) begin
					phase_d = field_idx_t'(phase_q + 3'd1);
				end else if ((ch == CH_DOT || ch == CH_COMMA) && phase_q == FLD_SECOND) begin
					phase_d = FLD_FRAC;
				end else begin
					verdict_d = V_BAD;
				end
			end
		end
	end

	always_comb begin
		result.status   = (verdict_d != V_OK);
		result.year     = to_out(store_d[FLD_YEAR]);
		result.month    = to_out(store_d[FLD_MONTH]);
		result.day      = to_out(store_d[FLD_DAY]);
		result.hour     = to_out(store_d[FLD_HOUR]);
		result.minute   = to_out(store_d[FLD_MINUTE]);
		result.second   = to_out(store_d[FLD_SECOND]);
		result.fraction = to_out(store_d[FLD_FRAC]);
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			phase_q   <= FLD_YEAR;
			acc_q     <= '0;
			neg_q     <= 1'b0;
			sign_q    <= 1'b0;
			dig_q     <= 1'b0;
			verdict_q <= V_OPEN;
			for (int i = 0; i < NUM_FIELDS; i++) store_q[i] <= '0;
		end else if (take) begin
			if (last) begin
				// string done: back to start for the next one
				phase_q   <= FLD_YEAR;
				acc_q     <= '0;
				neg_q     <= 1'b0;
				sign_q    <= 1'b0;
				dig_q     <= 1'b0;
				verdict_q <= V_OPEN;
				for (int i = 0; i < NUM_FIELDS; i++) store_q[i] <= '0;
			end else begin
				phase_q   <= phase_d;
				acc_q     <= acc_d;
				neg_q     <= neg_d;
				sign_q    <= sign_d;
				dig_q     <= dig_d;
				verdict_q <= verdict_d;
				store_q   <= store_d;
			end
		end
	end

endmodule

[sv/tsp_result_reg.sv]
module tsp_result_reg import tsp_pkg::*; (
	input  logic    clk,
	input  logic    arst_n,
	input  logic    load,
	input  result_t result_d,
	output logic    free,
	tsp_result_if.source results
);

	logic    valid_q;
	result_t data_q;

	// slot can take a new result if empty or being drained this cycle
	assign free = !valid_q || results.ready;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_q <= 1'b0;
		end else if (load) begin
			valid_q <= 1'b1;
		end else if (results.ready) begin
			valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (load) begin
			data_q <= result_d;
		end
	end

	assign results.valid    = valid_q;
	assign results.status   = data_q.status;
	assign results.year     = data_q.year;
	assign results.month    = data_q.month;
	assign results.day      = data_q.day;
	assign results.hour     = data_q.hour;
	assign results.minute   = data_q.minute;
	assign results.second   = data_q.second;
	assign results.fraction = data_q.fraction;

endmodule

[sv/iso8601_timestamp_parser_unit.sv]
// ISO 8601 timestamp parser.
// chars: one character per request (ch), last marks the final character of a
//   timestamp. Grammar: year[-month[-day]][Thour[:minute[:second[(.|,)frac]]]]Z.
// results: one request per timestamp, after its last character: status
//   (0 ok, 1 invalid) and the seven fields, sign-extended, zero where absent.
// Throughput: one character per cycle, except while a final character waits
//   for the result slot. The parse step (a x10 multiply-accumulate plus
//   separator decode) sits between the input register and the result register.
// Path: a last character passes the input register, then the result register,
//   before it shows on results.
// Stall: the result register holds until taken. Non-final characters keep
//   flowing while a result waits; a final character waits in the input
//   register until the result slot frees, and chars.ready drops meanwhile.
// Reset: arst_n clears the parse state, the input register and the result
//   valid; the block is ready for a new timestamp right after release.
module iso8601_timestamp_parser_unit import tsp_pkg::*; (
	input logic clk,
	input logic arst_n,
	tsp_char_if.sink     chars,
	tsp_result_if.source results
);

	logic       valid_s1;
	logic [7:0] ch_s1;
	logic       last_s1;
	logic       take;
	logic       slot_free;
	result_t    result_d;

	// a final character needs the result slot; others advance freely
	assign take        = valid_s1 && (!last_s1 || slot_free);
	assign chars.ready = !valid_s1 || take;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (chars.ready) begin
			valid_s1 <= chars.valid;
		end
	end

	always_ff @(posedge clk) begin
		if (chars.ready && chars.valid) begin
			ch_s1   <= chars.ch;
			last_s1 <= chars.last;
		end
	end

	tsp_field_parser u_parser (
		.clk    (clk),
		.arst_n (arst_n),
		.take   (take),
		.ch     (ch_s1),
		.last   (last_s1),
		.result (result_d)
	);

	tsp_result_reg u_result (
		.clk      (clk),
		.arst_n   (arst_n),
		.load     (take && last_s1),
		.result_d (result_d),
		.free     (slot_free),
		.results  (results)
	);

endmodule
